// ===== rtl/core/rigid_body_2d_integrator_unit_defines.svh =====
// Assertion macros shared by the rigid body integrator RTL.
// Each macro expects signals named clock and reset in the using scope.
`ifndef RIGID_BODY_2D_INTEGRATOR_UNIT_DEFINES_SVH
`define RIGID_BODY_2D_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RB2I_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define RB2I_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rb2i_pkg.sv =====
// Package for the 2D rigid body integrator: constants, item structs, enums,
// saturation helpers and the micro-program of the shared multiplier.
// No dependencies.
package rb2i_pkg;

   // Number formats
   localparam int FRAC_BITS = 16;
   localparam int DT_BITS   = 16;
   localparam int TQ_W      = 64 - FRAC_BITS;
   localparam int UPC_W     = 5;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [31:0] ONE_DT  = 32'sd65536;
   localparam logic [30:0]        ONE_Q   = 31'(1) << FRAC_BITS;
   localparam logic signed [31:0] RAD_TO_DEG_Q24 = 32'sd961263669;
   localparam logic signed [31:0] DEG_TO_RAD_Q32 = 32'sd74961321;
   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   // Request kinds
   localparam logic [2:0] REQ_STEP     = 3'd0;
   localparam logic [2:0] REQ_IMPULSE  = 3'd1;
   localparam logic [2:0] REQ_IMP_PT   = 3'd2;
   localparam logic [2:0] REQ_IMPACT   = 3'd3;
   localparam logic [2:0] REQ_POSE     = 3'd4;
   localparam logic [2:0] REQ_SET_SPIN = 3'd5;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_MASS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_MOMENT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_DRAG  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_DRAG = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_LOCK    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DYNAMIC_MODE = 3'd7;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [15:0]        delta_time;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] scalar_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } rb2i_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x_out;
      logic signed [31:0] pos_y_out;
      logic signed [31:0] rotation_out;
      logic signed [31:0] vel_x_out;
      logic signed [31:0] vel_y_out;
      logic signed [31:0] spin_out;
      logic signed [31:0] impact_vx;
      logic signed [31:0] impact_vy;
   } rb2i_rsp_type;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_type;

   typedef enum logic [2:0] {
      OP_STEP, OP_IMPULSE, OP_IMP_PT, OP_IMPACT, OP_POSE, OP_SPIN, OP_NOP
   } op_type;

   // Non-multiply work done in a micro step
   typedef enum logic [2:0] {
      PRE_NONE, PRE_GRAV, PRE_DIFF, PRE_POSE, PRE_SETSPIN, PRE_SPIN0
   } pre_type;

   // Multiplier operand sources
   typedef enum logic [4:0] {
      OPD_ZERO, OPD_VX, OPD_VY, OPD_SC, OPD_T0, OPD_T1, OPD_T2,
      OPD_VELX, OPD_VELY, OPD_SPIN, OPD_DX, OPD_DY, OPD_KL, OPD_KA,
      OPD_IM, OPD_IMOM, OPD_DT, OPD_LDRAG, OPD_ADRAG, OPD_R2D, OPD_D2R
   } opd_type;

   typedef enum logic [1:0] {SH_FRAC, SH_DT, SH_24, SH_32} sh_type;

   // Product writeback operations
   typedef enum logic [2:0] {
      WB_NONE, WB_LOAD, WB_ADD, WB_SUB, WB_KFACT, WB_TQ1, WB_TQ2
   } wb_type;

   typedef enum logic [3:0] {
      R_POSX, R_POSY, R_ROT, R_VELX, R_VELY, R_SPIN,
      R_T0, R_T1, R_T2, R_KL, R_KA, R_IX, R_IY
   } reg_type;

   typedef struct packed {
      pre_type pre;
      logic    iss;
      opd_type a_sel;
      opd_type b_sel;
      sh_type  sh;
      wb_type  wb;
      reg_type dst;
      reg_type base;
      logic    lk;
      logic    ang;
      logic    last;
   } uop_type;

   localparam uop_type UOP_NONE = '{
      pre: PRE_NONE, iss: 1'b0, a_sel: OPD_ZERO, b_sel: OPD_ZERO, sh: SH_FRAC,
      wb: WB_NONE, dst: R_T0, base: R_T0, lk: 1'b0, ang: 1'b0, last: 1'b0
   };

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[31:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [5:0] sh_amount(input sh_type s);
      logic [5:0] r;
      case (s)
         SH_FRAC: r = 6'(FRAC_BITS);
         SH_DT:   r = 6'(DT_BITS);
         SH_24:   r = 6'd24;
         SH_32:   r = 6'd32;
         default: r = 6'(FRAC_BITS);
      endcase
      return r;
   endfunction

   // Map request kind to operation; a static body turns a step into a no-op
   function automatic op_type decode_op(input logic [2:0] kind, input logic dyn);
      op_type r;
      case (kind)
         REQ_STEP:     r = dyn ? OP_STEP : OP_NOP;
         REQ_IMPULSE:  r = OP_IMPULSE;
         REQ_IMP_PT:   r = OP_IMP_PT;
         REQ_IMPACT:   r = OP_IMPACT;
         REQ_POSE:     r = OP_POSE;
         REQ_SET_SPIN: r = OP_SPIN;
         default:      r = OP_NOP;
      endcase
      return r;
   endfunction

   function automatic uop_type set_iss(input uop_type u, input opd_type a,
                                       input opd_type b, input sh_type s);
      uop_type r;
      r       = u;
      r.iss   = 1'b1;
      r.a_sel = a;
      r.b_sel = b;
      r.sh    = s;
      return r;
   endfunction

   function automatic uop_type set_wb(input uop_type u, input wb_type op,
                                      input reg_type dst, input reg_type base,
                                      input logic lk, input logic ang);
      uop_type r;
      r      = u;
      r.wb   = op;
      r.dst  = dst;
      r.base = base;
      r.lk   = lk;
      r.ang  = ang;
      return r;
   endfunction

   // Micro-program: a micro step may issue one product and may retire the one issued before it
   function automatic uop_type ucode(input op_type op, input logic [UPC_W-1:0] upc);
      uop_type u;
      u = UOP_NONE;
      case (op)
         OP_STEP: begin
            case (upc)
               5'd0:  u.pre = PRE_GRAV;
               5'd1:  u = set_iss(u, OPD_T0, OPD_IM, SH_FRAC);
               5'd2: begin
                  u = set_wb(u, WB_LOAD, R_T0, R_T0, 1'b0, 1'b0);
                  u = set_iss(u, OPD_T1, OPD_IM, SH_FRAC);
               end
               5'd3: begin
                  u = set_wb(u, WB_LOAD, R_T1, R_T1, 1'b0, 1'b0);
                  u = set_iss(u, OPD_T0, OPD_DT, SH_DT);
               end
               5'd4: begin
                  u = set_wb(u, WB_ADD, R_VELX, R_VELX, 1'b0, 1'b0);
                  u = set_iss(u, OPD_T1, OPD_DT, SH_DT);
               end
               5'd5: begin
                  u = set_wb(u, WB_ADD, R_VELY, R_VELY, 1'b0, 1'b0);
                  u = set_iss(u, OPD_LDRAG, OPD_DT, SH_DT);
               end
               5'd6: begin
                  u = set_wb(u, WB_KFACT, R_KL, R_KL, 1'b0, 1'b0);
                  u = set_iss(u, OPD_SC, OPD_IMOM, SH_FRAC);
               end
               5'd7: begin
                  u = set_wb(u, WB_LOAD, R_T2, R_T2, 1'b0, 1'b0);
                  u = set_iss(u, OPD_VELX, OPD_KL, SH_DT);
               end
               5'd8: begin
                  u = set_wb(u, WB_LOAD, R_VELX, R_VELX, 1'b1, 1'b0);
                  u = set_iss(u, OPD_VELY, OPD_KL, SH_DT);
               end
               5'd9: begin
                  u = set_wb(u, WB_LOAD, R_VELY, R_VELY, 1'b1, 1'b0);
                  u = set_iss(u, OPD_T2, OPD_R2D, SH_24);
               end
               5'd10: begin
                  u = set_wb(u, WB_LOAD, R_T2, R_T2, 1'b0, 1'b0);
                  u = set_iss(u, OPD_VELX, OPD_DT, SH_DT);
               end
               5'd11: begin
                  u = set_wb(u, WB_ADD, R_POSX, R_POSX, 1'b0, 1'b0);
                  u = set_iss(u, OPD_VELY, OPD_DT, SH_DT);
               end
               5'd12: begin
                  u = set_wb(u, WB_ADD, R_POSY, R_POSY, 1'b0, 1'b0);
                  u = set_iss(u, OPD_T2, OPD_DT, SH_DT);
               end
               5'd13: begin
                  u = set_wb(u, WB_ADD, R_SPIN, R_SPIN, 1'b0, 1'b1);
                  u = set_iss(u, OPD_ADRAG, OPD_DT, SH_DT);
               end
               5'd14: u = set_wb(u, WB_KFACT, R_KA, R_KA, 1'b0, 1'b0);
               5'd15: u = set_iss(u, OPD_SPIN, OPD_KA, SH_DT);
               5'd16: u = set_wb(u, WB_LOAD, R_SPIN, R_SPIN, 1'b0, 1'b1);
               5'd17: u = set_iss(u, OPD_SPIN, OPD_DT, SH_DT);
               5'd18: begin
                  u = set_wb(u, WB_ADD, R_ROT, R_ROT, 1'b0, 1'b1);
                  u.pre  = PRE_SPIN0;
                  u.last = 1'b1;
               end
               default: u.last = 1'b1;
            endcase
         end
         OP_IMPULSE: begin
            case (upc)
               5'd0: u = set_iss(u, OPD_VX, OPD_IM, SH_FRAC);
               5'd1: begin
                  u = set_wb(u, WB_ADD, R_VELX, R_VELX, 1'b1, 1'b0);
                  u = set_iss(u, OPD_VY, OPD_IM, SH_FRAC);
               end
               5'd2: begin
                  u = set_wb(u, WB_ADD, R_VELY, R_VELY, 1'b1, 1'b0);
                  u = set_iss(u, OPD_SC, OPD_IMOM, SH_FRAC);
               end
               5'd3: u = set_wb(u, WB_LOAD, R_T2, R_T2, 1'b0, 1'b0);
               5'd4: u = set_iss(u, OPD_T2, OPD_R2D, SH_24);
               5'd5: begin
                  u = set_wb(u, WB_ADD, R_SPIN, R_SPIN, 1'b0, 1'b1);
                  u.last = 1'b1;
               end
               default: u.last = 1'b1;
            endcase
         end
         OP_IMP_PT: begin
            case (upc)
               5'd0: u.pre = PRE_DIFF;
               5'd1: u = set_iss(u, OPD_VX, OPD_DY, SH_FRAC);
               5'd2: begin
                  u = set_wb(u, WB_TQ1, R_T2, R_T2, 1'b0, 1'b0);
                  u = set_iss(u, OPD_VY, OPD_DX, SH_FRAC);
               end
               5'd3: begin
                  u = set_wb(u, WB_TQ2, R_T2, R_T2, 1'b0, 1'b0);
                  u = set_iss(u, OPD_VX, OPD_IM, SH_FRAC);
               end
               5'd4: begin
                  u = set_wb(u, WB_ADD, R_VELX, R_VELX, 1'b1, 1'b0);
                  u = set_iss(u, OPD_VY, OPD_IM, SH_FRAC);
               end
               5'd5: begin
                  u = set_wb(u, WB_ADD, R_VELY, R_VELY, 1'b1, 1'b0);
                  u = set_iss(u, OPD_T2, OPD_IMOM, SH_FRAC);
               end
               5'd6: u = set_wb(u, WB_LOAD, R_T2, R_T2, 1'b0, 1'b0);
               5'd7: u = set_iss(u, OPD_T2, OPD_R2D, SH_24);
               5'd8: begin
                  u = set_wb(u, WB_ADD, R_SPIN, R_SPIN, 1'b0, 1'b1);
                  u.last = 1'b1;
               end
               default: u.last = 1'b1;
            endcase
         end
         OP_IMPACT: begin
            case (upc)
               5'd0: begin
                  u.pre = PRE_DIFF;
                  u = set_iss(u, OPD_SPIN, OPD_D2R, SH_32);
               end
               5'd1: u = set_wb(u, WB_LOAD, R_T2, R_T2, 1'b0, 1'b0);
               5'd2: u = set_iss(u, OPD_DY, OPD_T2, SH_FRAC);
               5'd3: begin
                  u = set_wb(u, WB_ADD, R_IX, R_VELX, 1'b0, 1'b0);
                  u = set_iss(u, OPD_DX, OPD_T2, SH_FRAC);
               end
               5'd4: begin
                  u = set_wb(u, WB_SUB, R_IY, R_VELY, 1'b0, 1'b0);
                  u.last = 1'b1;
               end
               default: u.last = 1'b1;
            endcase
         end
         OP_POSE: begin
            u.pre  = PRE_POSE;
            u.last = 1'b1;
         end
         OP_SPIN: begin
            u.pre  = PRE_SETSPIN;
            u.last = 1'b1;
         end
         default: u.last = 1'b1;
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/core/rigid_body_2d_integrator_unit.sv =====
// Top level of the 2D rigid body integrator: config registers, sequencer and
// shared multiplier datapath. Depends on rb2i_pkg and the assertion macros.
//
// Usage
//   Keeps one body's pose and velocities in Q16.16 and applies one request
//   per input item: integration step, impulse, impulse at a world point,
//   impact velocity query, pose load or spin set. Every item yields exactly
//   one result item with the state after it.
//   Input channel req_* and result channel rsp_* use valid/ready. The csr_*
//   port writes one register per cycle with csr_wr_en; write only while idle.
//   One item is in work at a time; the block takes the next item in the
//   cycle after the result is loaded. Work runs on the single 32x32
//   multiplier: at most one product is issued per micro step and retired
//   in the next micro step, and a step issues fifteen products.
//   The result sits in an output register: a new item is taken while it
//   waits, and a finished item holds in the wait state until the receiver
//   frees the register. Reset (synchronous) zeroes the body state, loads the
//   register defaults (unit inverse mass and moment, dynamic mode) and
//   drops any pending result.
`include "rigid_body_2d_integrator_unit_defines.svh"
module rigid_body_2d_integrator_unit
   import rb2i_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rb2i_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rb2i_rsp_type         rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   // Configuration registers
   logic signed [31:0] grav_x_ff, grav_x_in, grav_y_ff, grav_y_in;
   logic [30:0]        inv_mass_ff, inv_mass_in, inv_moment_ff, inv_moment_in;
   logic [15:0]        lin_drag_ff, lin_drag_in, ang_drag_ff, ang_drag_in;
   logic [2:0]         axis_lock_ff, axis_lock_in;
   logic               dyn_mode_ff, dyn_mode_in;

   // Sequencer
   state_type          state_ff, state_in;
   logic [UPC_W-1:0]   upc_ff, upc_in;
   op_type             op_ff, op_in;
   rb2i_req_type       req_ff, req_in;
   uop_type            uop;

   // Body state
   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, rot_ff, rot_in;
   logic signed [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in, spin_ff, spin_in;

   // Scratch
   logic signed [31:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic signed [31:0] kl_ff, kl_in, ka_ff, ka_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, ix_ff, ix_in, iy_ff, iy_in;
   logic signed [TQ_W-1:0] tq_ff, tq_in;

   // Multiplier and writeback
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff, prod_in, shifted;
   sh_type             sh_ff, sh_in;
   logic signed [31:0] res, base_val, wb_val;
   logic               wb_on, run, accept, slot_free, load_rsp;

   // Output register
   rb2i_rsp_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   function automatic logic signed [31:0] opd_val(input opd_type s);
      logic signed [31:0] r;
      case (s)
         OPD_VX:    r = req_ff.vec_x;
         OPD_VY:    r = req_ff.vec_y;
         OPD_SC:    r = req_ff.scalar_value;
         OPD_T0:    r = t0_ff;
         OPD_T1:    r = t1_ff;
         OPD_T2:    r = t2_ff;
         OPD_VELX:  r = vel_x_ff;
         OPD_VELY:  r = vel_y_ff;
         OPD_SPIN:  r = spin_ff;
         OPD_DX:    r = dx_ff;
         OPD_DY:    r = dy_ff;
         OPD_KL:    r = kl_ff;
         OPD_KA:    r = ka_ff;
         OPD_IM:    r = $signed({1'b0, inv_mass_ff});
         OPD_IMOM:  r = $signed({1'b0, inv_moment_ff});
         OPD_DT:    r = $signed({16'd0, req_ff.delta_time});
         OPD_LDRAG: r = $signed({16'd0, lin_drag_ff});
         OPD_ADRAG: r = $signed({16'd0, ang_drag_ff});
         OPD_R2D:   r = RAD_TO_DEG_Q24;
         OPD_D2R:   r = DEG_TO_RAD_Q32;
         default:   r = 32'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] reg_val(input reg_type s);
      logic signed [31:0] r;
      case (s)
         R_POSX:  r = pos_x_ff;
         R_POSY:  r = pos_y_ff;
         R_ROT:   r = rot_ff;
         R_VELX:  r = vel_x_ff;
         R_VELY:  r = vel_y_ff;
         R_SPIN:  r = spin_ff;
         R_T0:    r = t0_ff;
         R_T1:    r = t1_ff;
         R_T2:    r = t2_ff;
         R_KL:    r = kl_ff;
         R_KA:    r = ka_ff;
         R_IX:    r = ix_ff;
         R_IY:    r = iy_ff;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   // Handshake decode
   assign uop       = ucode(op_ff, upc_ff);
   assign run       = (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (uop.last) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_WAIT: load_rsp  = slot_free;
         default: begin
            req_ready = 1'b0;
            load_rsp  = 1'b0;
         end
      endcase
   end

   // Micro counter, operation and item capture
   always_comb begin
      upc_in = upc_ff;
      op_in  = op_ff;
      req_in = req_ff;
      if (accept) begin
         upc_in = '0;
         op_in  = decode_op(req_data.req_type, dyn_mode_ff);
         req_in = req_data;
      end else if (run) begin
         upc_in = upc_ff + 1'b1;
      end
   end

   // Configuration writes
   always_comb begin
      grav_x_in     = grav_x_ff;
      grav_y_in     = grav_y_ff;
      inv_mass_in   = inv_mass_ff;
      inv_moment_in = inv_moment_ff;
      lin_drag_in   = lin_drag_ff;
      ang_drag_in   = ang_drag_ff;
      axis_lock_in  = axis_lock_ff;
      dyn_mode_in   = dyn_mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRAVITY_X:    grav_x_in     = $signed(csr_wdata);
            CSR_GRAVITY_Y:    grav_y_in     = $signed(csr_wdata);
            CSR_INV_MASS:     inv_mass_in   = csr_wdata[30:0];
            CSR_INV_MOMENT:   inv_moment_in = csr_wdata[30:0];
            CSR_LINEAR_DRAG:  lin_drag_in   = csr_wdata[15:0];
            CSR_ANGULAR_DRAG: ang_drag_in   = csr_wdata[15:0];
            CSR_AXIS_LOCK:    axis_lock_in  = csr_wdata[2:0];
            CSR_DYNAMIC_MODE: dyn_mode_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Shared multiplier: issue one product, floor-shift and clamp the last one
   always_comb begin
      mul_a    = opd_val(uop.a_sel);
      mul_b    = opd_val(uop.b_sel);
      prod_in  = prod_ff;
      sh_in    = sh_ff;
      if (run && uop.iss) begin
         prod_in = mul_a * mul_b;
         sh_in   = uop.sh;
      end
      shifted  = prod_ff >>> sh_amount(sh_ff);
      res      = sat32(shifted);
      base_val = reg_val(uop.base);
      case (uop.wb)
         WB_ADD:   wb_val = sat32(64'(base_val) + 64'(res));
         WB_SUB:   wb_val = sat32(64'(base_val) - 64'(res));
         WB_KFACT: wb_val = ONE_DT - res;
         WB_TQ2:   wb_val = sat32(64'(tq_ff) - shifted);
         default:  wb_val = res;
      endcase
      // Drop velocity on locked axes
      if (uop.lk && uop.dst == R_VELX && axis_lock_ff[0]) wb_val = 32'sd0;
      if (uop.lk && uop.dst == R_VELY && axis_lock_ff[1]) wb_val = 32'sd0;
      wb_on = run && uop.wb != WB_NONE && !(uop.ang && axis_lock_ff[2]);
   end

   // Datapath register updates
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      rot_in   = rot_ff;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      spin_in  = spin_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      kl_in    = kl_ff;
      ka_in    = ka_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      ix_in    = ix_ff;
      iy_in    = iy_ff;
      tq_in    = tq_ff;

      // Impact fields read zero unless the query writes them
      if (accept) begin
         ix_in = 32'sd0;
         iy_in = 32'sd0;
      end

      if (run) begin
         case (uop.pre)
            PRE_GRAV: begin
               t0_in = sat32(64'(req_ff.vec_x) + 64'(grav_x_ff));
               t1_in = sat32(64'(req_ff.vec_y) + 64'(grav_y_ff));
            end
            PRE_DIFF: begin
               dx_in = sat32(64'(pos_x_ff) - 64'(req_ff.point_x));
               dy_in = sat32(64'(pos_y_ff) - 64'(req_ff.point_y));
            end
            PRE_POSE: begin
               pos_x_in = req_ff.point_x;
               pos_y_in = req_ff.point_y;
               rot_in   = req_ff.scalar_value;
            end
            PRE_SETSPIN: spin_in = req_ff.scalar_value;
            PRE_SPIN0: begin
               if (axis_lock_ff[2]) spin_in = 32'sd0;
            end
            default: ;
         endcase
      end

      if (wb_on && uop.wb == WB_TQ1) begin
         tq_in = shifted[TQ_W-1:0];
      end else if (wb_on) begin
         case (uop.dst)
            R_POSX:  pos_x_in = wb_val;
            R_POSY:  pos_y_in = wb_val;
            R_ROT:   rot_in   = wb_val;
            R_VELX:  vel_x_in = wb_val;
            R_VELY:  vel_y_in = wb_val;
            R_SPIN:  spin_in  = wb_val;
            R_T0:    t0_in    = wb_val;
            R_T1:    t1_in    = wb_val;
            R_T2:    t2_in    = wb_val;
            R_KL:    kl_in    = wb_val;
            R_KA:    ka_in    = wb_val;
            R_IX:    ix_in    = wb_val;
            R_IY:    iy_in    = wb_val;
            default: ;
         endcase
      end
   end

   // Output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_in.pos_x_out    = pos_x_ff;
         rsp_in.pos_y_out    = pos_y_ff;
         rsp_in.rotation_out = rot_ff;
         rsp_in.vel_x_out    = vel_x_ff;
         rsp_in.vel_y_out    = vel_y_ff;
         rsp_in.spin_out     = spin_ff;
         rsp_in.impact_vx    = ix_ff;
         rsp_in.impact_vy    = iy_ff;
         rsp_valid_in        = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         upc_ff        <= '0;
         op_ff         <= OP_NOP;
         rsp_valid_ff  <= 1'b0;
         grav_x_ff     <= 32'sd0;
         grav_y_ff     <= 32'sd0;
         inv_mass_ff   <= ONE_Q;
         inv_moment_ff <= ONE_Q;
         lin_drag_ff   <= 16'd0;
         ang_drag_ff   <= 16'd0;
         axis_lock_ff  <= 3'd0;
         dyn_mode_ff   <= 1'b1;
         pos_x_ff      <= 32'sd0;
         pos_y_ff      <= 32'sd0;
         rot_ff        <= 32'sd0;
         vel_x_ff      <= 32'sd0;
         vel_y_ff      <= 32'sd0;
         spin_ff       <= 32'sd0;
      end else begin
         state_ff      <= state_in;
         upc_ff        <= upc_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
         grav_x_ff     <= grav_x_in;
         grav_y_ff     <= grav_y_in;
         inv_mass_ff   <= inv_mass_in;
         inv_moment_ff <= inv_moment_in;
         lin_drag_ff   <= lin_drag_in;
         ang_drag_ff   <= ang_drag_in;
         axis_lock_ff  <= axis_lock_in;
         dyn_mode_ff   <= dyn_mode_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         rot_ff        <= rot_in;
         vel_x_ff      <= vel_x_in;
         vel_y_ff      <= vel_y_in;
         spin_ff       <= spin_in;
      end
   end

   // Payload and scratch registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      kl_ff   <= kl_in;
      ka_ff   <= ka_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      ix_ff   <= ix_in;
      iy_ff   <= iy_in;
      tq_ff   <= tq_in;
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      rsp_ff  <= rsp_in;
   end

   // Checks
   `RB2I_ASSERT_NEXT(a_accept_starts, accept, state_ff == ST_RUN && upc_ff == '0, "accepted item did not start at micro step zero")
   `RB2I_ASSERT_NEXT(a_static_step_nop, accept && req_data.req_type == REQ_STEP && !dyn_mode_ff, op_ff == OP_NOP, "static step was not turned into a no-op")
   `RB2I_ASSERT_NEXT(a_impact_zero, load_rsp && op_ff != OP_IMPACT, rsp_ff.impact_vx == 32'sd0 && rsp_ff.impact_vy == 32'sd0, "impact fields nonzero outside impact query")
   `RB2I_ASSERT_NOW(a_x_lock, state_ff == ST_WAIT && axis_lock_ff[0] && (op_ff == OP_STEP || op_ff == OP_IMPULSE || op_ff == OP_IMP_PT), vel_x_ff == 32'sd0, "x velocity moved under x lock")
   `RB2I_ASSERT_NOW(a_rot_lock, state_ff == ST_WAIT && axis_lock_ff[2] && op_ff == OP_STEP, spin_ff == 32'sd0, "spin not cleared by step under rotation lock")

endmodule

// ===== bench/rigid_body_2d_integrator_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for rigid_body_2d_integrator_unit: directed and random request
// items under several register settings, with random idling and a long receiver stall.
// Depends on rb2i_pkg and the RTL top level; results are checked against a local predictor.
module rigid_body_2d_integrator_unit_tb;
   import rb2i_pkg::*;

   // Request codes the block decodes as no-ops
   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   localparam int IDLE_PCT       = 14;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 40;
   localparam int STALL_CYCLES   = 300;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;
   localparam logic signed [31:0] Q_ONE = 32'sh00010000;
   localparam logic signed [31:0] G_EARTH = -32'sd642908;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   rb2i_req_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rb2i_rsp_type         rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   bit  idle_on = 1'b1;
   int  mismatch_count = 0;
   int  stall_count = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;

   rb2i_rsp_type expected_state_q[$];
   logic [31:0]  next_settings[8];

   rigid_body_2d_integrator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predicted body state and register copy, starting from the reset values
   // ---------------------------------------------------------------------------
   longint     body_px = 0, body_py = 0, body_rot = 0;
   longint     body_vx = 0, body_vy = 0, body_spin = 0;
   longint     cfg_grav_x = 0, cfg_grav_y = 0;
   longint     cfg_inv_mass = 65536, cfg_inv_moment = 65536;
   longint     cfg_lin_drag = 0, cfg_ang_drag = 0;
   logic [2:0] cfg_lock = 3'b000;
   logic       cfg_dynamic = 1'b1;

   function automatic longint clamp32(input longint v);
      if (v > longint'(Q_MAX)) return longint'(Q_MAX);
      if (v < longint'(Q_MIN)) return longint'(Q_MIN);
      return v;
   endfunction

   // Product floored by the shift, then clamped
   function automatic longint fx_mul(input longint a, input longint b, input int s);
      return clamp32((a * b) >>> s);
   endfunction

   function automatic longint drag_keep(input longint drag, input longint dt);
      return longint'(ONE_DT) - ((drag * dt) >>> DT_BITS);
   endfunction

   // Linear impulse plus angular impulse (degrees)
   function automatic void kick_body(input longint jx, input longint jy, input longint ang);
      longint a;
      body_vx = clamp32(body_vx + fx_mul(jx, cfg_inv_mass, FRAC_BITS));
      body_vy = clamp32(body_vy + fx_mul(jy, cfg_inv_mass, FRAC_BITS));
      if (cfg_lock[0]) body_vx = 0;
      if (cfg_lock[1]) body_vy = 0;
      if (!cfg_lock[2]) begin
         a = fx_mul(ang, cfg_inv_moment, FRAC_BITS);
         body_spin = clamp32(body_spin + fx_mul(a, longint'(RAD_TO_DEG_Q24), 24));
      end
   endfunction

   // Semi-implicit Euler step; a static body drops the frame entirely
   function automatic void integrate_body(input longint dt, input longint fx_in,
                                          input longint fy_in, input longint torque);
      longint fx, fy, k, a;
      if (!cfg_dynamic) return;
      fx = clamp32(fx_in + cfg_grav_x);
      fy = clamp32(fy_in + cfg_grav_y);
      body_vx = clamp32(body_vx + fx_mul(fx_mul(fx, cfg_inv_mass, FRAC_BITS), dt, DT_BITS));
      body_vy = clamp32(body_vy + fx_mul(fx_mul(fy, cfg_inv_mass, FRAC_BITS), dt, DT_BITS));
      k = drag_keep(cfg_lin_drag, dt);
      body_vx = fx_mul(body_vx, k, DT_BITS);
      body_vy = fx_mul(body_vy, k, DT_BITS);
      if (cfg_lock[0]) body_vx = 0;
      if (cfg_lock[1]) body_vy = 0;
      body_px = clamp32(body_px + fx_mul(body_vx, dt, DT_BITS));
      body_py = clamp32(body_py + fx_mul(body_vy, dt, DT_BITS));
      if (!cfg_lock[2]) begin
         a = fx_mul(fx_mul(torque, cfg_inv_moment, FRAC_BITS), longint'(RAD_TO_DEG_Q24), 24);
         body_spin = clamp32(body_spin + fx_mul(a, dt, DT_BITS));
         body_spin = fx_mul(body_spin, drag_keep(cfg_ang_drag, dt), DT_BITS);
         body_rot = clamp32(body_rot + fx_mul(body_spin, dt, DT_BITS));
      end else begin
         body_spin = 0;
      end
   endfunction

   // Advance the predicted body by one request item and return the expected result
   function automatic rb2i_rsp_type predict_after_item(input rb2i_req_type item);
      rb2i_rsp_type r;
      longint dt, vx, vy, sc, px, py, dx, dy, w, tq, ix, iy;
      dt = longint'(item.delta_time);
      vx = longint'($signed(item.vec_x));
      vy = longint'($signed(item.vec_y));
      sc = longint'($signed(item.scalar_value));
      px = longint'($signed(item.point_x));
      py = longint'($signed(item.point_y));
      ix = 0;
      iy = 0;
      case (item.req_type)
         REQ_STEP:    integrate_body(dt, vx, vy, sc);
         REQ_IMPULSE: kick_body(vx, vy, sc);
         REQ_IMP_PT: begin
            dx = clamp32(body_px - px);
            dy = clamp32(body_py - py);
            tq = ((vx * dy) >>> FRAC_BITS) - ((vy * dx) >>> FRAC_BITS);
            kick_body(vx, vy, clamp32(tq));
         end
         REQ_IMPACT: begin
            dx = clamp32(body_px - px);
            dy = clamp32(body_py - py);
            w  = fx_mul(body_spin, longint'(DEG_TO_RAD_Q32), 32);
            ix = clamp32(body_vx + fx_mul(dy, w, FRAC_BITS));
            iy = clamp32(body_vy - fx_mul(dx, w, FRAC_BITS));
         end
         REQ_POSE: begin
            body_px  = px;
            body_py  = py;
            body_rot = sc;
         end
         REQ_SET_SPIN: body_spin = sc;
         default: ;
      endcase
      r.pos_x_out    = 32'(body_px);
      r.pos_y_out    = 32'(body_py);
      r.rotation_out = 32'(body_rot);
      r.vel_x_out    = 32'(body_vx);
      r.vel_y_out    = 32'(body_vy);
      r.spin_out     = 32'(body_spin);
      r.impact_vx    = 32'(ix);
      r.impact_vy    = 32'(iy);
      return r;
   endfunction

   function automatic void store_setting(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [31:0] val);
      case (idx)
         CSR_GRAVITY_X:    cfg_grav_x     = longint'($signed(val));
         CSR_GRAVITY_Y:    cfg_grav_y     = longint'($signed(val));
         CSR_INV_MASS:     cfg_inv_mass   = longint'(val & 32'h7FFFFFFF);
         CSR_INV_MOMENT:   cfg_inv_moment = longint'(val & 32'h7FFFFFFF);
         CSR_LINEAR_DRAG:  cfg_lin_drag   = longint'(val[15:0]);
         CSR_ANGULAR_DRAG: cfg_ang_drag   = longint'(val[15:0]);
         CSR_AXIS_LOCK:    cfg_lock       = val[2:0];
         CSR_DYNAMIC_MODE: cfg_dynamic    = val[0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      end
   endfunction

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      rb2i_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_state_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result item with nothing expected: %h", $time, rsp_data);
         end else begin
            want = expected_state_q.pop_front();
            check_field("pos_x_out",    want.pos_x_out,    rsp_data.pos_x_out);
            check_field("pos_y_out",    want.pos_y_out,    rsp_data.pos_y_out);
            check_field("rotation_out", want.rotation_out, rsp_data.rotation_out);
            check_field("vel_x_out",    want.vel_x_out,    rsp_data.vel_x_out);
            check_field("vel_y_out",    want.vel_y_out,    rsp_data.vel_y_out);
            check_field("spin_out",     want.spin_out,     rsp_data.spin_out);
            check_field("impact_vx",    want.impact_vx,    rsp_data.impact_vx);
            check_field("impact_vy",    want.impact_vy,    rsp_data.impact_vy);
         end
      end
   end

   // Count cycles without any handshake; end the run if the block locks up
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("rigid_body_2d_integrator_unit_tb: FAIL");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // Receiver: random idling, plus a long hold whenever a test asks for one
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_ready   <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left   <= STALL_CYCLES;
      end else begin
         rsp_ready <= !(idle_on && ($urandom_range(99) < IDLE_PCT));
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic rb2i_req_type make_item(input logic [2:0] kind, input logic [15:0] dt,
                                              input logic signed [31:0] vx,
                                              input logic signed [31:0] vy,
                                              input logic signed [31:0] sc,
                                              input logic signed [31:0] px,
                                              input logic signed [31:0] py);
      rb2i_req_type it;
      it.req_type     = kind;
      it.delta_time   = dt;
      it.vec_x        = vx;
      it.vec_y        = vy;
      it.scalar_value = sc;
      it.point_x      = px;
      it.point_y      = py;
      return it;
   endfunction

   // Mostly moderate magnitudes so the body keeps moving; sometimes full range
   function automatic logic signed [31:0] rand_q();
      logic signed [31:0] r;
      int unsigned pick;
      pick = $urandom_range(99);
      r = $urandom;
      if (pick < 40) begin
         r = r >>> 13;
      end else if (pick < 70) begin
         r = r >>> 7;
      end else if (pick >= 90) begin
         case ($urandom_range(4))
            0: r = Q_MAX;
            1: r = Q_MIN;
            2: r = '0;
            3: r = Q_ONE;
            default: r = -Q_ONE;
         endcase
      end
      return r;
   endfunction

   function automatic logic [15:0] rand_dt();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) return 16'($urandom_range(1, 4096));
      if (pick < 85) return 16'($urandom_range(0, 65535));
      return (pick < 92) ? 16'h0000 : 16'hFFFF;
   endfunction

   function automatic logic [31:0] rand_inverse();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'h7FFFFFFF;
         2: return $urandom;
         3: return 32'd65536;
         default: return $urandom_range(1, 1 << 18);
      endcase
   endfunction

   function automatic logic [31:0] rand_drag();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h0000FFFF;
         default: return $urandom_range(0, 8192);
      endcase
   endfunction

   function automatic rb2i_req_type random_item();
      rb2i_req_type it;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35)      it.req_type = REQ_STEP;
      else if (pick < 50) it.req_type = REQ_IMPULSE;
      else if (pick < 63) it.req_type = REQ_IMP_PT;
      else if (pick < 78) it.req_type = REQ_IMPACT;
      else if (pick < 87) it.req_type = REQ_POSE;
      else if (pick < 95) it.req_type = REQ_SET_SPIN;
      else                it.req_type = (pick < 98) ? REQ_SPARE_A : REQ_SPARE_B;
      it.delta_time   = rand_dt();
      it.vec_x        = rand_q();
      it.vec_y        = rand_q();
      it.scalar_value = rand_q();
      it.point_x      = rand_q();
      it.point_y      = rand_q();
      return it;
   endfunction

   function automatic void load_reset_settings();
      next_settings[CSR_GRAVITY_X]    = 32'd0;
      next_settings[CSR_GRAVITY_Y]    = 32'd0;
      next_settings[CSR_INV_MASS]     = 32'd65536;
      next_settings[CSR_INV_MOMENT]   = 32'd65536;
      next_settings[CSR_LINEAR_DRAG]  = 32'd0;
      next_settings[CSR_ANGULAR_DRAG] = 32'd0;
      next_settings[CSR_AXIS_LOCK]    = 32'd0;
      next_settings[CSR_DYNAMIC_MODE] = 32'd1;
   endfunction

   function automatic void pick_random_settings();
      next_settings[CSR_GRAVITY_X]    = rand_q();
      next_settings[CSR_GRAVITY_Y]    = rand_q();
      next_settings[CSR_INV_MASS]     = rand_inverse();
      next_settings[CSR_INV_MOMENT]   = rand_inverse();
      next_settings[CSR_LINEAR_DRAG]  = rand_drag();
      next_settings[CSR_ANGULAR_DRAG] = rand_drag();
      case ($urandom_range(7))
         0: next_settings[CSR_AXIS_LOCK] = $urandom;
         1, 2: next_settings[CSR_AXIS_LOCK] = $urandom_range(0, 7);
         default: next_settings[CSR_AXIS_LOCK] = 32'd0;
      endcase
      next_settings[CSR_DYNAMIC_MODE] = ($urandom_range(7) == 0) ? $urandom : 32'd1;
   endfunction

   // Write every register from next_settings; call only while the block is idle
   task automatic apply_settings();
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= next_settings[i];
         @(posedge clock);
         store_setting(CSR_IDX_W'(i), next_settings[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Offer one item, idling first at random, and predict it once accepted
   task automatic send_item(input rb2i_req_type item);
      while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_state_q.push_back(predict_after_item(item));
   endtask

   // Drop valid and wait until every expected result has arrived
   task automatic stop_and_drain();
      req_valid <= 1'b0;
      while (expected_state_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_items(input int count);
      for (int n = 0; n < count; n++) send_item(random_item());
      stop_and_drain();
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes and every request kind under the reset settings
   task automatic test_directed_defaults();
      send_item(make_item(REQ_POSE, 16'h0000, '0, '0, Q_MAX, Q_MAX, Q_MIN));
      send_item(make_item(REQ_IMPACT, 16'hFFFF, Q_MAX, Q_MIN, '0, Q_MIN, Q_MAX));
      send_item(make_item(REQ_SET_SPIN, 16'h0000, '0, '0, Q_MIN, '0, '0));
      send_item(make_item(REQ_IMPACT, 16'h0000, '0, '0, '0, '0, '0));
      send_item(make_item(REQ_STEP, 16'hFFFF, Q_MAX, Q_MIN, Q_MAX, '0, '0));
      send_item(make_item(REQ_STEP, 16'h0000, Q_MIN, Q_MAX, Q_MIN, '0, '0));
      send_item(make_item(REQ_POSE, 16'h0000, '0, '0, '0, '0, '0));
      send_item(make_item(REQ_SET_SPIN, 16'h0000, '0, '0, 32'sh01680000, '0, '0));
      send_item(make_item(REQ_IMPACT, 16'h0000, '0, '0, '0, Q_ONE, -Q_ONE));
      send_item(make_item(REQ_IMPULSE, 16'h0000, Q_MIN, Q_MAX, Q_MIN, '0, '0));
      send_item(make_item(REQ_IMP_PT, 16'h0000, 32'sh00050000, -32'sh00030000, '0,
                          Q_MAX, Q_MIN));
      send_item(make_item(REQ_STEP, 16'h0444, Q_ONE, -Q_ONE, Q_ONE, '0, '0));
      // Unused codes leave the state alone whatever the fields hold
      send_item(make_item(REQ_SPARE_A, 16'hFFFF, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_item(make_item(REQ_SPARE_B, 16'hA5A5, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      stop_and_drain();
   endtask

   // Static body, rotation lock and single axis lock
   task automatic test_static_and_locks();
      load_reset_settings();
      next_settings[CSR_DYNAMIC_MODE] = 32'd0;
      next_settings[CSR_GRAVITY_Y]    = G_EARTH;
      apply_settings();
      send_item(make_item(REQ_POSE, 16'h0000, '0, '0, 32'sh002D0000, Q_ONE, Q_ONE));
      // Impulses still act on a static body; a step changes nothing
      send_item(make_item(REQ_IMPULSE, 16'h0000, 32'sh00020000, -32'sh00010000, Q_ONE,
                          '0, '0));
      send_item(make_item(REQ_STEP, 16'h0444, Q_MAX, Q_MAX, Q_MAX, '0, '0));
      send_item(make_item(REQ_IMP_PT, 16'h0000, Q_ONE, Q_ONE, '0, '0, 32'sh00030000));
      stop_and_drain();

      next_settings[CSR_DYNAMIC_MODE] = 32'd1;
      next_settings[CSR_AXIS_LOCK]    = 32'd7;
      next_settings[CSR_LINEAR_DRAG]  = 32'h0000FFFF;
      next_settings[CSR_ANGULAR_DRAG] = 32'h0000FFFF;
      apply_settings();
      // Spin set under rotation lock is still written, then the step clears it
      send_item(make_item(REQ_SET_SPIN, 16'h0000, '0, '0, 32'sh005A0000, '0, '0));
      send_item(make_item(REQ_STEP, 16'h0444, Q_ONE, Q_ONE, Q_ONE, '0, '0));
      send_item(make_item(REQ_IMPULSE, 16'h0000, Q_ONE, Q_ONE, Q_ONE, '0, '0));
      stop_and_drain();

      next_settings[CSR_AXIS_LOCK] = 32'd1;
      apply_settings();
      send_item(make_item(REQ_STEP, 16'h0444, Q_ONE, '0, Q_ONE, '0, '0));
      send_item(make_item(REQ_IMP_PT, 16'h0000, Q_ONE, -Q_ONE, '0, Q_ONE, -Q_ONE));
      send_item(make_item(REQ_IMPACT, 16'h0000, '0, '0, '0, -Q_ONE, Q_ONE));
      stop_and_drain();
   endtask

   task automatic test_default_random();
      load_reset_settings();
      apply_settings();
      send_random_items(150);
   endtask

   // Extreme settings first, then a run of random settings
   task automatic test_setting_sweep();
      next_settings[CSR_GRAVITY_X]    = Q_MAX;
      next_settings[CSR_GRAVITY_Y]    = Q_MAX;
      next_settings[CSR_INV_MASS]     = 32'hFFFFFFFF;
      next_settings[CSR_INV_MOMENT]   = 32'hFFFFFFFF;
      next_settings[CSR_LINEAR_DRAG]  = 32'hFFFFFFFF;
      next_settings[CSR_ANGULAR_DRAG] = 32'hFFFFFFFF;
      next_settings[CSR_AXIS_LOCK]    = 32'hFFFFFFF8;
      next_settings[CSR_DYNAMIC_MODE] = 32'hFFFFFFFF;
      apply_settings();
      send_random_items(50);

      next_settings[CSR_GRAVITY_X]    = Q_MIN;
      next_settings[CSR_GRAVITY_Y]    = Q_MIN;
      next_settings[CSR_INV_MASS]     = 32'd0;
      next_settings[CSR_INV_MOMENT]   = 32'd0;
      next_settings[CSR_LINEAR_DRAG]  = 32'd0;
      next_settings[CSR_ANGULAR_DRAG] = 32'd0;
      next_settings[CSR_AXIS_LOCK]    = 32'd0;
      next_settings[CSR_DYNAMIC_MODE] = 32'd1;
      apply_settings();
      send_random_items(50);

      for (int p = 0; p < 10; p++) begin
         pick_random_settings();
         apply_settings();
         send_random_items(55);
      end
   endtask

   task automatic test_no_idle_burst();
      idle_on = 1'b0;
      pick_random_settings();
      next_settings[CSR_DYNAMIC_MODE] = 32'd1;
      apply_settings();
      send_random_items(150);
      idle_on = 1'b1;
   endtask

   // Hold the receiver off while items keep coming so the input backs up
   task automatic test_receiver_stall();
      load_reset_settings();
      apply_settings();
      hold_requests = hold_requests + 1;
      send_random_items(60);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_static_and_locks();
      test_default_random();
      test_setting_sweep();
      test_no_idle_burst();
      test_receiver_stall();

      stop_and_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_state_q.size() == 0) begin
         $display("rigid_body_2d_integrator_unit_tb: PASS");
      end else begin
         $display("rigid_body_2d_integrator_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== rigid_body_2d_integrator_unit.f =====
+incdir+rtl/core
rtl/core/rb2i_pkg.sv
rtl/core/rigid_body_2d_integrator_unit.sv
bench/rigid_body_2d_integrator_unit_tb.sv
